[design/pms_pkg.sv]
package pms_pkg;

    // Coordinate width of points and strip vertices
    localparam int CoordBits = 16;
    localparam int ColorW    = 32;
    localparam int HwW       = 12;
    localparam logic [HwW-1:0] HwReset = 12'd16;

    // Configuration port
    localparam int AddrW = 3;
    localparam int DataW = 32;
    localparam logic RegHalfWidth = 1'b0;

    // Vector to normalize: segment delta or sum of two unit vectors
    localparam int VecW = (CoordBits + 1 > 19) ? CoordBits + 1 : 19;
    // Magnitude register, wide enough to hold the vector and the [2^30, 2^31) window
    localparam int MagW = (VecW > 31) ? VecW : 31;
    // Q16 unit vector component, covers +/-65536
    localparam int UW   = 18;
    // Vertex offset
    localparam int OffW = 17;
    localparam int SumW = ((CoordBits > OffW) ? CoordBits : OffW) + 1;

    // Shared multiplier
    localparam int MulW  = 32;
    localparam int ProdW = 64;

    // Square root unit
    localparam int SqW   = 64;
    localparam int RootW = 32;

    // Divider: quotient bits, divisor bits, dividend bits
    localparam int DivQW = 17;
    localparam int DivDW = 32;
    localparam int DivNW = DivQW + DivDW - 1;

    // Miter divisor (Q16) and its floor of 1/4
    localparam int DotW = 18;
    localparam logic [DotW-1:0] DotMin = 18'd16384;

endpackage

[design/pms_sqrt.sv]
module pms_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pms_pkg::SqW-1:0]   radicand,
    output logic                      done,
    output logic [pms_pkg::RootW-1:0] root
);
    import pms_pkg::*;

    logic [SqW-1:0] rem_reg;
    logic [SqW-1:0] res_reg;
    logic [SqW-1:0] bit_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [SqW-1:0] trial;
    logic           fits;

    // One result bit per cycle, two radicand bits consumed per step
    always_comb
    begin
        trial = res_reg + bit_reg;
        fits  = (rem_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= radicand;
            res_reg  <= '0;
            bit_reg  <= SqW'(1) << (SqW - 2);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = res_reg[RootW-1:0];

endmodule

[design/pms_div.sv]
module pms_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pms_pkg::DivNW-1:0] num,
    input  logic [pms_pkg::DivDW-1:0] den,
    output logic                      done,
    output logic [pms_pkg::DivQW-1:0] quot
);
    import pms_pkg::*;

    localparam int CntW = $clog2(DivQW + 1);

    logic [DivDW-1:0] rem_reg;
    logic [DivQW-1:0] low_reg;
    logic [DivQW-1:0] q_reg;
    logic [DivDW-1:0] den_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DivDW:0]   trial;
    logic [DivDW:0]   diff;
    logic             ge;

    // Restoring division, one quotient bit per cycle; the caller keeps
    // the high dividend bits below the divisor
    always_comb
    begin
        trial = {rem_reg, low_reg[DivQW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= {1'b0, num[DivNW-1:DivQW]};
            low_reg  <= num[DivQW-1:0];
            den_reg  <= den;
            q_reg    <= '0;
            cnt_reg  <= CntW'(DivQW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[DivQW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[design/polyline_miter_strip.sv]
// Channel   Direction  Handshake                     Payload
// config    in/out     psel/penable/pwrite, pready   paddr, pwdata, prdata (half_width)
// point     in         point_valid / point_ready     point_x, point_y, point_color, end_of_line
// vertex    out        vertex_valid / vertex_ready   vertex_x, vertex_y, vertex_color,
//                                                    strip_done, degenerate, run_last
//
// A first point is absorbed with no vertices. A later point runs a normalization (load and,
// for a nonzero vector, shift steps, the squaring steps, the serial square root and two serial
// divisions) and a cap product; a miter point adds a second normalization, a dot product and,
// unless the incoming segment is zero, two miter divisions before the vertices. Vertices leave
// one per cycle; a stalled vertex holds the output register and the sequencer, and the next
// request is taken once the last vertex is in the output register. rst_n clears the point
// history, sets half_width to 16 and drops any pending vertex.
module polyline_miter_strip (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pms_pkg::AddrW-1:0]           paddr,
    input  logic [pms_pkg::DataW-1:0]           pwdata,
    output logic [pms_pkg::DataW-1:0]           prdata,
    output logic                                pready,
    // point requests
    input  logic                                point_valid,
    output logic                                point_ready,
    input  logic signed [pms_pkg::CoordBits-1:0] point_x,
    input  logic signed [pms_pkg::CoordBits-1:0] point_y,
    input  logic [pms_pkg::ColorW-1:0]          point_color,
    input  logic                                end_of_line,
    // strip vertices
    output logic                                vertex_valid,
    input  logic                                vertex_ready,
    output logic signed [pms_pkg::CoordBits-1:0] vertex_x,
    output logic signed [pms_pkg::CoordBits-1:0] vertex_y,
    output logic [pms_pkg::ColorW-1:0]          vertex_color,
    output logic                                strip_done,
    output logic                                degenerate,
    output logic                                run_last
);
    import pms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD_B,
        S_LOAD_T,
        S_SHIFT,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_CAP_X,
        S_CAP_Y,
        S_CAP_FIN,
        S_DOT_X,
        S_DOT_Y,
        S_DOT_SUM,
        S_MX_MUL,
        S_MX_GO,
        S_MX_WAIT,
        S_MY_MUL,
        S_MY_GO,
        S_MY_WAIT,
        S_EMIT
    } state_t;

    // Config register
    logic [HwW-1:0] hw_reg;

    // Sequencer and point history
    state_t                       state_reg;
    logic [1:0]                   ps_reg;
    logic signed [CoordBits-1:0]  prev_x_reg, prev_y_reg;
    logic [ColorW-1:0]            prev_color_reg;
    logic signed [CoordBits-1:0]  cur_x_reg, cur_y_reg;
    logic [ColorW-1:0]            cur_color_reg;
    logic                         eol_reg;

    // Unit vectors: incoming segment (a), outgoing segment (b), bisector (t)
    logic signed [UW-1:0]         a_x_reg, a_y_reg, b_x_reg, b_y_reg, t_x_reg, t_y_reg;
    logic                         a_ok_reg, b_ok_reg;
    logic                         sel_t_reg;

    // Normalization datapath
    logic [MagW-1:0]              ax_reg, ay_reg;
    logic                         sx_reg, sy_reg;
    logic [SqW-1:0]               sq_reg;
    logic signed [ProdW-1:0]      prod_reg;
    logic [DivQW-1:0]             qx_reg;

    // Offsets
    logic signed [OffW-1:0]       cox_reg, coy_reg, mox_reg, moy_reg;
    logic [DotW-1:0]              dot_reg;
    logic                         clamp_reg;
    logic                         msign_reg;
    logic [1:0]                   idx_reg;

    // Output register
    logic                         out_vld_reg;
    logic signed [CoordBits-1:0]  out_x_reg, out_y_reg;
    logic [ColorW-1:0]            out_color_reg;
    logic                         out_done_reg, out_deg_reg, out_last_reg;

    // Combinational helpers
    logic signed [VecW-1:0]       vec_x, vec_y;
    logic [VecW-1:0]              vmag_x, vmag_y;
    logic [MagW-1:0]              mag_or;
    logic signed [MulW-1:0]       mul_a, mul_b;
    logic [ProdW-1:0]             pmag;
    logic [OffW-1:0]              rq;
    logic signed [ProdW-1:0]      dsum;
    logic signed [ProdW-1:0]      dsum_rnd;
    logic                         sqrt_start, sqrt_done;
    logic [RootW-1:0]             sqrt_root;
    logic                         div_start, div_done;
    logic [DivNW-1:0]             div_num;
    logic [DivDW-1:0]             div_den;
    logic [DivQW-1:0]             div_quot;
    logic                         u_fin, u_ok, u_sel;
    logic signed [UW-1:0]         u_x, u_y;
    logic                         out_free;
    logic                         accept;
    logic signed [CoordBits-1:0]  e_base_x, e_base_y;
    logic signed [OffW-1:0]       e_off_x, e_off_y;
    logic signed [SumW-1:0]       e_sum_x, e_sum_y;
    logic                         e_last, e_deg;

    function automatic logic signed [CoordBits-1:0] sat_coord(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] cmax;
        logic signed [SumW-1:0] cmin;
        cmax = $signed({{(SumW-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}});
        cmin = ~cmax;
        if (v > cmax)
            return cmax[CoordBits-1:0];
        else if (v < cmin)
            return cmin[CoordBits-1:0];
        else
            return v[CoordBits-1:0];
    endfunction

    // Config port: a single register decoded on the word address bit
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegHalfWidth) ? DataW'(hw_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hw_reg <= HwReset;
        else if (psel && penable && pwrite && pready && (paddr[2] == RegHalfWidth))
            hw_reg <= pwdata[HwW-1:0];
    end

    assign point_ready = (state_reg == S_IDLE);
    assign accept      = point_valid && point_ready;
    assign out_free    = !out_vld_reg || vertex_ready;

    // Vector to normalize: new segment, or the sum of the two segment directions
    always_comb
    begin
        if (state_reg == S_LOAD_T)
        begin
            vec_x = VecW'(a_x_reg) + VecW'(b_x_reg);
            vec_y = VecW'(a_y_reg) + VecW'(b_y_reg);
        end
        else
        begin
            vec_x = VecW'(cur_x_reg) - VecW'(prev_x_reg);
            vec_y = VecW'(cur_y_reg) - VecW'(prev_y_reg);
        end
        vmag_x = vec_x[VecW-1] ? VecW'(-vec_x) : VecW'(vec_x);
        vmag_y = vec_y[VecW-1] ? VecW'(-vec_y) : VecW'(vec_y);
        mag_or = ax_reg | ay_reg;
    end

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = MulW'({1'b0, ax_reg[30:0]});
                mul_b = MulW'({1'b0, ax_reg[30:0]});
            end
            S_SQY:
            begin
                mul_a = MulW'({1'b0, ay_reg[30:0]});
                mul_b = MulW'({1'b0, ay_reg[30:0]});
            end
            S_CAP_X:
            begin
                mul_a = MulW'({1'b0, hw_reg});
                mul_b = MulW'(b_y_reg);
            end
            S_CAP_Y:
            begin
                mul_a = MulW'({1'b0, hw_reg});
                mul_b = MulW'(b_x_reg);
            end
            S_DOT_X:
            begin
                mul_a = MulW'(t_x_reg);
                mul_b = MulW'(a_x_reg);
            end
            S_DOT_Y:
            begin
                mul_a = MulW'(t_y_reg);
                mul_b = MulW'(a_y_reg);
            end
            S_MX_MUL:
            begin
                mul_a = MulW'({1'b0, hw_reg});
                mul_b = -MulW'(t_y_reg);
            end
            S_MY_MUL:
            begin
                mul_a = MulW'({1'b0, hw_reg});
                mul_b = MulW'(t_x_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the last product: halves away from zero, divide by 2^16
    always_comb
    begin
        pmag     = prod_reg[ProdW-1] ? ProdW'(-prod_reg) : ProdW'(prod_reg);
        rq       = OffW'((pmag + ProdW'(32768)) >> 16);
        dsum     = $signed(sq_reg) + prod_reg;
        dsum_rnd = (dsum + ProdW'(32768)) >>> 16;
    end

    // Serial units
    assign sqrt_start = (state_reg == S_ROOT_GO);
    assign div_start  = (state_reg inside {S_DX_GO, S_DY_GO, S_MX_GO, S_MY_GO});

    always_comb
    begin
        case (state_reg)
            S_DX_GO:
            begin
                div_num = DivNW'({ax_reg[30:0], 16'b0}) + DivNW'(sqrt_root >> 1);
                div_den = DivDW'(sqrt_root);
            end
            S_DY_GO:
            begin
                div_num = DivNW'({ay_reg[30:0], 16'b0}) + DivNW'(sqrt_root >> 1);
                div_den = DivDW'(sqrt_root);
            end
            S_MX_GO, S_MY_GO:
            begin
                div_num = DivNW'(pmag) + DivNW'(dot_reg >> 1);
                div_den = DivDW'(dot_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    pms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // End of a normalization: zero vector right at load, or last division done
    always_comb
    begin
        u_sel = (state_reg == S_LOAD_T) || ((state_reg != S_LOAD_B) && sel_t_reg);
        u_fin = 1'b0;
        u_ok  = 1'b0;
        u_x   = '0;
        u_y   = '0;
        if (((state_reg == S_LOAD_B) || (state_reg == S_LOAD_T)) &&
            (vmag_x == '0) && (vmag_y == '0))
        begin
            u_fin = 1'b1;
        end
        else if ((state_reg == S_DY_WAIT) && div_done)
        begin
            u_fin = 1'b1;
            u_ok  = 1'b1;
            u_x   = sx_reg ? -UW'({1'b0, qx_reg}) : UW'({1'b0, qx_reg});
            u_y   = sy_reg ? -UW'({1'b0, div_quot}) : UW'({1'b0, div_quot});
        end
    end

    // Vertex of the current emit slot: slots 0/1 sit at the previous point,
    // slots 2/3 are the end cap at the current point; the minus side goes first
    always_comb
    begin
        if (idx_reg[1])
        begin
            e_base_x = cur_x_reg;
            e_base_y = cur_y_reg;
        end
        else
        begin
            e_base_x = prev_x_reg;
            e_base_y = prev_y_reg;
        end
        if (!idx_reg[1] && (ps_reg == 2'd2))
        begin
            e_off_x = mox_reg;
            e_off_y = moy_reg;
            e_deg   = !a_ok_reg || clamp_reg || !b_ok_reg;
        end
        else
        begin
            e_off_x = cox_reg;
            e_off_y = coy_reg;
            e_deg   = !b_ok_reg;
        end
        if (idx_reg[0])
        begin
            e_sum_x = SumW'(e_base_x) + SumW'(e_off_x);
            e_sum_y = SumW'(e_base_y) + SumW'(e_off_y);
        end
        else
        begin
            e_sum_x = SumW'(e_base_x) - SumW'(e_off_x);
            e_sum_y = SumW'(e_base_y) - SumW'(e_off_y);
        end
        e_last = (idx_reg == 2'd3) || ((idx_reg == 2'd1) && !eol_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ps_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_color_reg <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_color_reg  <= '0;
            eol_reg        <= 1'b0;
            a_x_reg        <= '0;
            a_y_reg        <= '0;
            a_ok_reg       <= 1'b0;
            b_x_reg        <= '0;
            b_y_reg        <= '0;
            b_ok_reg       <= 1'b0;
            t_x_reg        <= '0;
            t_y_reg        <= '0;
            sel_t_reg      <= 1'b0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            sx_reg         <= 1'b0;
            sy_reg         <= 1'b0;
            sq_reg         <= '0;
            prod_reg       <= '0;
            qx_reg         <= '0;
            cox_reg        <= '0;
            coy_reg        <= '0;
            mox_reg        <= '0;
            moy_reg        <= '0;
            dot_reg        <= '0;
            clamp_reg      <= 1'b0;
            msign_reg      <= 1'b0;
            idx_reg        <= '0;
            out_vld_reg    <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_color_reg  <= '0;
            out_done_reg   <= 1'b0;
            out_deg_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Drop a vertex once taken; in the emit step the next vertex refills it
            if (vertex_ready && (state_reg != S_EMIT))
                out_vld_reg <= 1'b0;

            if (u_fin)
            begin
                if (u_sel)
                begin
                    t_x_reg   <= u_x;
                    t_y_reg   <= u_y;
                    state_reg <= S_DOT_X;
                end
                else
                begin
                    b_x_reg   <= u_x;
                    b_y_reg   <= u_y;
                    b_ok_reg  <= u_ok;
                    state_reg <= S_CAP_X;
                end
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            idx_reg <= '0;
                            if (ps_reg == 2'd0)
                            begin
                                // First point: hold it, no vertices
                                prev_x_reg     <= point_x;
                                prev_y_reg     <= point_y;
                                prev_color_reg <= point_color;
                                ps_reg         <= end_of_line ? 2'd0 : 2'd1;
                            end
                            else
                            begin
                                cur_x_reg     <= point_x;
                                cur_y_reg     <= point_y;
                                cur_color_reg <= point_color;
                                eol_reg       <= end_of_line;
                                state_reg     <= S_LOAD_B;
                            end
                        end
                    end
                    S_LOAD_B, S_LOAD_T:
                    begin
                        sel_t_reg <= (state_reg == S_LOAD_T);
                        ax_reg    <= MagW'(vmag_x);
                        ay_reg    <= MagW'(vmag_y);
                        sx_reg    <= vec_x[VecW-1];
                        sy_reg    <= vec_y[VecW-1];
                        state_reg <= S_SHIFT;
                    end
                    S_SHIFT:
                    begin
                        // Bring the larger magnitude into [2^30, 2^31)
                        if ((mag_or >> 31) != '0)
                        begin
                            ax_reg <= ax_reg >> 1;
                            ay_reg <= ay_reg >> 1;
                        end
                        else if ((mag_or >> 30) == '0)
                        begin
                            ax_reg <= ax_reg << 1;
                            ay_reg <= ay_reg << 1;
                        end
                        else
                        begin
                            state_reg <= S_SQX;
                        end
                    end
                    S_SQX:
                    begin
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_SQY;
                    end
                    S_SQY:
                    begin
                        sq_reg    <= SqW'(prod_reg);
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_SQSUM;
                    end
                    S_SQSUM:
                    begin
                        sq_reg    <= sq_reg + SqW'(prod_reg);
                        state_reg <= S_ROOT_GO;
                    end
                    S_ROOT_GO:
                    begin
                        state_reg <= S_ROOT_WAIT;
                    end
                    S_ROOT_WAIT:
                    begin
                        if (sqrt_done)
                            state_reg <= S_DX_GO;
                    end
                    S_DX_GO:
                    begin
                        state_reg <= S_DX_WAIT;
                    end
                    S_DX_WAIT:
                    begin
                        if (div_done)
                        begin
                            qx_reg    <= div_quot;
                            state_reg <= S_DY_GO;
                        end
                    end
                    S_DY_GO:
                    begin
                        state_reg <= S_DY_WAIT;
                    end
                    S_DY_WAIT:
                    begin
                        // finish is handled above on the divider's done
                    end
                    S_CAP_X:
                    begin
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_CAP_Y;
                    end
                    S_CAP_Y:
                    begin
                        // Cap normal is (-by, bx)
                        cox_reg   <= prod_reg[ProdW-1] ? $signed(rq) : -$signed(rq);
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_CAP_FIN;
                    end
                    S_CAP_FIN:
                    begin
                        coy_reg   <= prod_reg[ProdW-1] ? -$signed(rq) : $signed(rq);
                        state_reg <= (ps_reg == 2'd2) ? S_LOAD_T : S_EMIT;
                    end
                    S_DOT_X:
                    begin
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_DOT_Y;
                    end
                    S_DOT_Y:
                    begin
                        sq_reg    <= SqW'(prod_reg);
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_DOT_SUM;
                    end
                    S_DOT_SUM:
                    begin
                        // Clamp the miter divisor at 1/4
                        if (dsum < $signed(ProdW'(64'd1073741824)))
                        begin
                            dot_reg   <= DotMin;
                            clamp_reg <= 1'b1;
                        end
                        else
                        begin
                            dot_reg   <= dsum_rnd[DotW-1:0];
                            clamp_reg <= 1'b0;
                        end
                        if (a_ok_reg)
                        begin
                            state_reg <= S_MX_MUL;
                        end
                        else
                        begin
                            mox_reg   <= '0;
                            moy_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                    S_MX_MUL:
                    begin
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_MX_GO;
                    end
                    S_MX_GO:
                    begin
                        msign_reg <= prod_reg[ProdW-1];
                        state_reg <= S_MX_WAIT;
                    end
                    S_MX_WAIT:
                    begin
                        if (div_done)
                        begin
                            mox_reg   <= msign_reg ? -$signed(OffW'(div_quot))
                                                   : $signed(OffW'(div_quot));
                            state_reg <= S_MY_MUL;
                        end
                    end
                    S_MY_MUL:
                    begin
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_MY_GO;
                    end
                    S_MY_GO:
                    begin
                        msign_reg <= prod_reg[ProdW-1];
                        state_reg <= S_MY_WAIT;
                    end
                    S_MY_WAIT:
                    begin
                        if (div_done)
                        begin
                            moy_reg   <= msign_reg ? -$signed(OffW'(div_quot))
                                                   : $signed(OffW'(div_quot));
                            state_reg <= S_EMIT;
                        end
                    end
                    S_EMIT:
                    begin
                        if (out_free)
                        begin
                            out_vld_reg   <= 1'b1;
                            out_x_reg     <= sat_coord(e_sum_x);
                            out_y_reg     <= sat_coord(e_sum_y);
                            out_color_reg <= idx_reg[1] ? cur_color_reg : prev_color_reg;
                            out_done_reg  <= (idx_reg == 2'd3);
                            out_deg_reg   <= e_deg;
                            out_last_reg  <= e_last;
                            idx_reg       <= idx_reg + 1'b1;
                            if (e_last)
                            begin
                                // Advance the history; an end mark clears it
                                prev_x_reg     <= cur_x_reg;
                                prev_y_reg     <= cur_y_reg;
                                prev_color_reg <= cur_color_reg;
                                a_x_reg        <= b_x_reg;
                                a_y_reg        <= b_y_reg;
                                a_ok_reg       <= b_ok_reg;
                                ps_reg         <= eol_reg ? 2'd0 : 2'd2;
                                state_reg      <= S_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign vertex_valid = out_vld_reg;
    assign vertex_x     = out_x_reg;
    assign vertex_y     = out_y_reg;
    assign vertex_color = out_color_reg;
    assign strip_done   = out_done_reg;
    assign degenerate   = out_deg_reg;
    assign run_last     = out_last_reg;

endmodule

[design/pms_chk.sv]
module pms_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [pms_pkg::AddrW-1:0]            paddr,
    input logic [pms_pkg::DataW-1:0]            pwdata,
    input logic [pms_pkg::DataW-1:0]            prdata,
    input logic                                 pready,
    input logic                                 point_valid,
    input logic                                 point_ready,
    input logic signed [pms_pkg::CoordBits-1:0] point_x,
    input logic signed [pms_pkg::CoordBits-1:0] point_y,
    input logic [pms_pkg::ColorW-1:0]           point_color,
    input logic                                 end_of_line,
    input logic                                 vertex_valid,
    input logic                                 vertex_ready,
    input logic signed [pms_pkg::CoordBits-1:0] vertex_x,
    input logic signed [pms_pkg::CoordBits-1:0] vertex_y,
    input logic [pms_pkg::ColorW-1:0]           vertex_color,
    input logic                                 strip_done,
    input logic                                 degenerate,
    input logic                                 run_last
);
    import pms_pkg::*;

    // The end-cap vertex closing a strip is always the last of its point
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && strip_done |-> run_last)
        else $error("strip_done without run_last");

    // Vertices of one point leave back to back
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && !run_last |=> vertex_valid)
        else $error("gap inside a vertex run");

    // A stalled vertex holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_ready |=>
            vertex_valid && $stable(vertex_x) && $stable(vertex_y) && $stable(run_last))
        else $error("stalled vertex changed");

    // Read data carries only the half_width bits
    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        pready && (prdata[DataW-1:HwW] == '0))
        else $error("config read data out of range");

endmodule

bind polyline_miter_strip pms_chk u_pms_chk (.*);

[dv/polyline_miter_strip_test.sv]
module polyline_miter_strip_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pms_pkg::*;

    // Q16 constants of the fixed-point geometry
    localparam longint OneQ16      = 65536;
    localparam longint DotFloorQ16 = 16384;
    localparam int     CycleLimit  = 1500000;
    // Settling time after the last vertex: one full miter point plus margin
    localparam int     DrainCycles = 400;
    localparam logic [AddrW-1:0] HalfWidthAddr = AddrW'(4 * RegHalfWidth);

    typedef struct {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [ColorW-1:0]           color;
        logic                        eol;
    } point_t;

    typedef struct {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [ColorW-1:0]           color;
        logic                        done;
        logic                        deg;
        logic                        last;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    logic                        point_valid = 1'b0;
    logic                        point_ready;
    logic signed [CoordBits-1:0] point_x = '0;
    logic signed [CoordBits-1:0] point_y = '0;
    logic [ColorW-1:0]           point_color = '0;
    logic                        end_of_line = 1'b0;

    logic                        vertex_valid;
    logic                        vertex_ready = 1'b0;
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic [ColorW-1:0]           vertex_color;
    logic                        strip_done;
    logic                        degenerate;
    logic                        run_last;

    polyline_miter_strip i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_color  (point_color),
        .end_of_line  (end_of_line),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_color (vertex_color),
        .strip_done   (strip_done),
        .degenerate   (degenerate),
        .run_last     (run_last)
    );

    always #10 clk = ~clk;

    // Points waiting to be driven, and vertices the strip must still produce
    point_t  pending_points[$];
    vertex_t strip_vertices[$];

    int idle_pct = 0;     // chance in percent that the sender idles a cycle
    int stall_pct = 0;    // chance in percent that the receiver stalls a cycle
    int cycles = 0;
    int errors = 0;
    int points_taken = 0;
    int vertices_seen = 0;
    int lines_sent = 0;

    // Shadow of the block: configuration and point history
    longint half_width_q = 16;
    longint older_x, older_y, last_x, last_y;
    logic [ColorW-1:0] last_color;
    int     points_in_line;

    // ------------------------------------------------------------------
    // Fixed-point geometry of the strip
    // ------------------------------------------------------------------
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Q16 unit vector; returns 0 and a zero vector for a zero input
    function automatic bit normalize(input longint dx, input longint dy,
                                     output longint ux, output longint uy);
        longint unsigned ax, ay, m, len, qx, qy;
        ax = abs64(dx);
        ay = abs64(dy);
        m = ax > ay ? ax : ay;
        ux = 0;
        uy = 0;
        if (m == 0)
            return 1'b0;
        while (m < (64'd1 << 30))
        begin
            ax <<= 1;
            ay <<= 1;
            m <<= 1;
        end
        while (m >= (64'd1 << 31))
        begin
            ax >>= 1;
            ay >>= 1;
            m >>= 1;
        end
        len = floor_sqrt(ax * ax + ay * ay);
        qx = (ax * OneQ16 + len / 2) / len;
        qy = (ay * OneQ16 + len / 2) / len;
        ux = dx < 0 ? -longint'(qx) : longint'(qx);
        uy = dy < 0 ? -longint'(qy) : longint'(qy);
        return 1'b1;
    endfunction

    // Round to nearest, halves away from zero; den is positive
    function automatic longint round_div(input longint num, input longint den);
        longint unsigned q;
        q = (abs64(num) + longint'(den) / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [CoordBits-1:0] clamp_coord(input longint v);
        longint hi;
        hi = (longint'(1) << (CoordBits - 1)) - 1;
        if (v > hi)
            return hi[CoordBits-1:0];
        if (v < -hi - 1)
            return CoordBits'(-hi - 1);
        return v[CoordBits-1:0];
    endfunction

    function automatic void add_vertex(input longint x, input longint y,
                                       input logic [ColorW-1:0] color,
                                       input logic done, input logic deg);
        vertex_t v;
        v.x = clamp_coord(x);
        v.y = clamp_coord(y);
        v.color = color;
        v.done = done;
        v.deg = deg;
        v.last = 1'b0;
        strip_vertices.push_back(v);
    endfunction

    // Pair at (px,py) offset along the unit normal of segment a->b
    function automatic void add_cap(input longint px, input longint py,
                                    input longint ax, input longint ay,
                                    input longint bx, input longint by,
                                    input logic [ColorW-1:0] color, input logic done);
        longint nx, ny, ox, oy;
        bit ok;
        ok = normalize(-(by - ay), bx - ax, nx, ny);
        ox = round_div(half_width_q * nx, OneQ16);
        oy = round_div(half_width_q * ny, OneQ16);
        add_vertex(px - ox, py - oy, color, 1'b0, !ok);
        add_vertex(px + ox, py + oy, color, done, !ok);
    endfunction

    // Miter pair at the previous point, given the incoming point (cx,cy)
    function automatic void add_miter(input longint cx, input longint cy);
        longint nx, ny, ax, ay, bx, by, tx, ty, mx, my, sum, dot;
        longint ox, oy;
        bit in_ok, out_ok, deg;
        ox = 0;
        oy = 0;
        deg = 1'b0;
        in_ok = normalize(-(last_y - older_y), last_x - older_x, nx, ny);
        out_ok = normalize(cx - last_x, cy - last_y, bx, by);
        void'(normalize(last_x - older_x, last_y - older_y, ax, ay));
        void'(normalize(ax + bx, ay + by, tx, ty));
        mx = -ty;
        my = tx;
        if (!in_ok)
            deg = 1'b1;
        else
        begin
            sum = mx * nx + my * ny;
            if (sum < DotFloorQ16 * OneQ16)
            begin
                dot = DotFloorQ16;
                deg = 1'b1;
            end
            else
                dot = (sum + OneQ16 / 2) / OneQ16;
            ox = round_div(half_width_q * mx, dot);
            oy = round_div(half_width_q * my, dot);
        end
        if (!out_ok)
            deg = 1'b1;
        add_vertex(last_x - ox, last_y - oy, last_color, 1'b0, deg);
        add_vertex(last_x + ox, last_y + oy, last_color, 1'b0, deg);
    endfunction

    function automatic void clear_line();
        older_x = 0;
        older_y = 0;
        last_x = 0;
        last_y = 0;
        last_color = '0;
        points_in_line = 0;
    endfunction

    // Advance the shadow by one accepted point and queue its vertices
    function automatic void predict_strip(input point_t p);
        int first_new;
        longint x, y;
        first_new = strip_vertices.size();
        x = longint'(p.x);
        y = longint'(p.y);
        if (points_in_line == 0)
            points_in_line = 1;
        else if (points_in_line == 1)
        begin
            add_cap(last_x, last_y, last_x, last_y, x, y, last_color, 1'b0);
            points_in_line = 2;
        end
        else
            add_miter(x, y);
        older_x = last_x;
        older_y = last_y;
        last_x = x;
        last_y = y;
        last_color = p.color;
        if (p.eol)
        begin
            if (points_in_line == 2)
                add_cap(last_x, last_y, older_x, older_y, last_x, last_y,
                        last_color, 1'b1);
            clear_line();
        end
        if (strip_vertices.size() > first_new)
            strip_vertices[strip_vertices.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: advance to the next pending point once the current one is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!point_valid || point_ready))
        begin
            if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                point_t p;
                p = pending_points.pop_front();
                point_x <= p.x;
                point_y <= p.y;
                point_color <= p.color;
                end_of_line <= p.eol;
                point_valid <= 1'b1;
            end
            else
                point_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            vertex_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted requests, check every accepted vertex
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && point_valid && point_ready)
        begin
            point_t p;
            p.x = point_x;
            p.y = point_y;
            p.color = point_color;
            p.eol = end_of_line;
            predict_strip(p);
            points_taken++;
        end
        if (rst_n && vertex_valid && vertex_ready)
        begin
            vertices_seen++;
            if (strip_vertices.size() == 0)
            begin
                $error("vertex with none expected: x=%0d y=%0d", vertex_x, vertex_y);
                errors++;
            end
            else
            begin
                vertex_t e;
                e = strip_vertices.pop_front();
                if (vertex_x !== e.x)
                begin
                    $error("vertex_x expected %0d actual %0d", e.x, vertex_x);
                    errors++;
                end
                if (vertex_y !== e.y)
                begin
                    $error("vertex_y expected %0d actual %0d", e.y, vertex_y);
                    errors++;
                end
                if (vertex_color !== e.color)
                begin
                    $error("vertex_color expected %h actual %h", e.color, vertex_color);
                    errors++;
                end
                if (strip_done !== e.done)
                begin
                    $error("strip_done expected %0b actual %0b", e.done, strip_done);
                    errors++;
                end
                if (degenerate !== e.deg)
                begin
                    $error("degenerate expected %0b actual %0b", e.deg, degenerate);
                    errors++;
                end
                if (run_last !== e.last)
                begin
                    $error("run_last expected %0b actual %0b", e.last, run_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_point(input longint x, input longint y, input logic eol);
        point_t p;
        p.x = CoordBits'(x);
        p.y = CoordBits'(y);
        p.color = $urandom;
        p.eol = eol;
        pending_points.push_back(p);
        if (eol)
            lines_sent++;
    endtask

    // Hold until the block has drained every request and vertex; sample
    // between edges so the driver's updates of this cycle are settled
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_points.size() != 0 || point_valid ||
               strip_vertices.size() != 0 || !point_ready);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_half_width(input logic [HwW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HalfWidthAddr;
        pwdata <= DataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        half_width_q = longint'(value);
        // read back
        @(posedge clk);
        psel <= 1'b1;
        paddr <= HalfWidthAddr;
        @(posedge clk);
        penable <= 1'b1;
        #1;
        if (prdata[HwW-1:0] !== value)
        begin
            $error("half_width expected %0d actual %0d", value, prdata[HwW-1:0]);
            errors++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed lines: nearby points, some repeats and wide jumps
    task automatic queue_random_points(input int count);
        longint x, y, step;
        int n, len;
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(6, 1);
            step = ($urandom_range(3) == 0) ? 32767 : $urandom_range(2000, 1);
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(9))
                    0: ;  // repeat the point: zero-length segment
                    1:
                    begin
                        x = $signed(16'($urandom));
                        y = $signed(16'($urandom));
                    end
                    2:    // turn back over the previous segment
                    begin
                        x = x - longint'($urandom_range(4000));
                        y = y - longint'($urandom_range(40));
                    end
                    default:
                    begin
                        x = x + longint'($urandom_range(2 * step)) - step;
                        y = y + longint'($urandom_range(2 * step)) - step;
                    end
                endcase
                x = longint'($signed(16'(x)));
                y = longint'($signed(16'(y)));
                // a few broken lines end early or never end
                queue_point(x, y, (i == len - 1) ? ($urandom_range(19) != 0)
                                                 : ($urandom_range(29) == 0));
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_line();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset half width
        queue_point(100, 100, 1'b1);                // lone point
        queue_point(0, 0, 1'b0);                    // two-point line
        queue_point(160, 0, 1'b1);
        queue_point(0, 0, 1'b0);                    // straight, right angle, acute
        queue_point(100, 0, 1'b0);
        queue_point(200, 0, 1'b0);
        queue_point(200, 100, 1'b0);
        queue_point(0, 90, 1'b1);
        queue_point(50, 50, 1'b0);                  // zero cap segment
        queue_point(50, 50, 1'b1);
        queue_point(10, 10, 1'b0);                  // zero incoming at a miter
        queue_point(10, 10, 1'b0);
        queue_point(90, 40, 1'b1);
        queue_point(0, 0, 1'b0);                    // U-turn
        queue_point(300, 0, 1'b0);
        queue_point(0, 0, 1'b1);
        queue_point(-32768, -32768, 1'b0);          // coordinate extremes
        queue_point(32767, 32767, 1'b0);
        queue_point(-32768, 32767, 1'b1);
        wait_drained();

        // Saturation with the widest line
        write_half_width(12'd4095);
        queue_point(32767, 0, 1'b0);
        queue_point(32767, 32767, 1'b0);
        queue_point(-32768, 32767, 1'b1);
        queue_point(-32768, -32768, 1'b0);
        queue_point(32767, -32768, 1'b1);
        wait_drained();

        // Random phases: each sets a half width and an idling pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_half_width(12'd0);
                1: write_half_width(12'd1);
                2: write_half_width(12'd4095);
                default: write_half_width(HwW'($urandom_range(4095)));
            endcase
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                3: begin idle_pct = 7;  stall_pct = 7;  end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            queue_random_points(40);
            // pause the sender mid-phase until the strip has drained
            wait_drained();
            queue_random_points(40);
            wait_drained();
        end
        write_half_width(HwReset);

        $display("covered %0d points in %0d terminated lines, %0d vertices checked",
                 points_taken, lines_sent, vertices_seen);
        $display("half widths 0, 1, 16, 4095 and random; sender and receiver idling mixes");
        if (errors == 0 && strip_vertices.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/pms_pkg.sv
design/pms_sqrt.sv
design/pms_div.sv
design/polyline_miter_strip.sv
design/pms_chk.sv
dv/polyline_miter_strip_test.sv
